/* rtl/adsr_pkg.sv */
// adsr_pkg: shared widths, codes, register indexes and item types
// for the adsr envelope level block; no dependencies
`default_nettype none
package adsr_pkg;

  localparam int TIME_W    = 32;
  localparam int TICK_W    = 24;
  localparam int LVL_W     = 16;
  localparam int PROD_W    = TICK_W + LVL_W;
  localparam int Q_W       = LVL_W;
  localparam int DIV_STAGES = Q_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TICK_W;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [LVL_W-1:0] LEVEL_ONE = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd5;

  typedef enum logic [2:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_SILENT  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SEG_ATTACK  = 2'd0,
    SEG_DECAY   = 2'd1,
    SEG_SUSTAIN = 2'd2
  } seg_t;

  typedef struct packed {
    logic [TICK_W-1:0] attack;
    logic [TICK_W-1:0] decay;
    logic [LVL_W-1:0]  sustain;
    logic [TICK_W-1:0] release_t;
    logic [LVL_W-1:0]  peak;
    logic [LVL_W-1:0]  floor_l;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic              silent;
    logic              held;
    seg_t              seg;
    logic              zero_att;
    logic [TICK_W-1:0] mul_a;
    logic [TICK_W-1:0] rel_e;
  } item_t;

  typedef struct packed {
    logic push;
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

/* rtl/adsr_envelope_level.sv */
// adsr_envelope_level: top level, config registers, front, queue and back
// depends on adsr_pkg, adsr_front, adsr_queue, adsr_back
//
//  channel | ports                              | transfer
//  input   | start, busy, in_now/on/off_time    | start && !busy
//  result  | out_strobe, out_level/phase/finish | out_strobe, one cycle
//  config  | cfg_we, cfg_index, cfg_wdata       | cfg_we
//
// one item per cycle; a transfer passes the front, the queue and the back
// part with its two 16-stage divider pipelines (one bit per stage).
// synchronous reset clears valid bits and loads register defaults.
// busy stays low: the back part drains the queue every cycle and the
// receiver cannot stall.
`default_nettype none
module adsr_envelope_level (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [adsr_pkg::TIME_W-1:0]     in_now_time,
  input  wire logic [adsr_pkg::TIME_W-1:0]     in_on_time,
  input  wire logic [adsr_pkg::TIME_W-1:0]     in_off_time,
  input  wire logic                            cfg_we,
  input  wire logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                                 out_strobe,
  output logic [adsr_pkg::LVL_W-1:0]           out_level,
  output logic [2:0]                           out_phase,
  output logic                                 out_finished
);
  import adsr_pkg::*;

  cfg_t   cfg_r;
  logic   f_valid;
  item_t  f_item;
  logic   q_valid;
  item_t  q_item;
  qstat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack    <= 24'd4410;
      cfg_r.decay     <= 24'd4410;
      cfg_r.sustain   <= 16'd32768;
      cfg_r.release_t <= 24'd8820;
      cfg_r.peak      <= 16'd32768;
      cfg_r.floor_l   <= 16'd328;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK:  cfg_r.attack    <= cfg_wdata;
        REG_DECAY:   cfg_r.decay     <= cfg_wdata;
        REG_SUSTAIN: cfg_r.sustain   <= cfg_wdata[LVL_W-1:0];
        REG_RELEASE: cfg_r.release_t <= cfg_wdata;
        REG_PEAK:    cfg_r.peak      <= cfg_wdata[LVL_W-1:0];
        REG_FLOOR:   cfg_r.floor_l   <= cfg_wdata[LVL_W-1:0];
        default:     ;
      endcase
    end
  end

  assign busy = 1'b0;

  adsr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_now   (in_now_time),
    .in_on    (in_on_time),
    .in_off   (in_off_time),
    .cfg      (cfg_r),
    .out_valid(f_valid),
    .out_item (f_item)
  );

  adsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_item (f_item),
    .pop       (1'b1),
    .head_valid(q_valid),
    .head_item (q_item),
    .stat      (q_stat)
  );

  adsr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (q_valid),
    .in_item     (q_item),
    .cfg         (cfg_r),
    .out_strobe  (out_strobe),
    .out_level   (out_level),
    .out_phase   (out_phase),
    .out_finished(out_finished)
  );

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.push && q_stat.full))
    else $error("queue overflow");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##39 out_strobe)
    else $error("result missing after transfer");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_level <= LEVEL_ONE))
    else $error("level above one");

  a_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_finished == (out_level == '0)))
    else $error("finished flag mismatch");

endmodule
`default_nettype wire

/* rtl/adsr_div.sv */
// adsr_div: pipelined restoring divider, one quotient bit per stage
// depends on adsr_pkg
`default_nettype none
module adsr_div (
  input  wire logic                        clk,
  input  wire logic [adsr_pkg::PROD_W-1:0] in_dividend,
  input  wire logic [adsr_pkg::TICK_W-1:0] in_divisor,
  output logic      [adsr_pkg::Q_W-1:0]    out_quot
);
  import adsr_pkg::*;

  logic [PROD_W-1:0] rem_r [DIV_STAGES];
  logic [TICK_W-1:0] dvs_r [DIV_STAGES];
  logic [Q_W-1:0]    q_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [PROD_W-1:0] rem_in;
    logic [TICK_W-1:0] dvs_in;
    logic [Q_W-1:0]    q_in;
    logic [PROD_W-1:0] trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = in_dividend;
      assign dvs_in = in_divisor;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dvs_in = dvs_r[k-1];
      assign q_in   = q_r[k-1];
    end

    // stage k decides quotient bit DIV_STAGES-1-k
    assign trial = PROD_W'(dvs_in) << (DIV_STAGES - 1 - k);
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      rem_r[k] <= take ? rem_in - trial : rem_in;
      dvs_r[k] <= dvs_in;
      q_r[k]   <= q_in | (take ? Q_W'(1) << (DIV_STAGES - 1 - k) : '0);
    end
  end

  assign out_quot = q_r[DIV_STAGES-1];

endmodule
`default_nettype wire

/* rtl/adsr_front.sv */
// adsr_front: takes tick times, forms ages and classifies the segment
// depends on adsr_pkg
`default_nettype none
module adsr_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic [adsr_pkg::TIME_W-1:0] in_now,
  input  wire logic [adsr_pkg::TIME_W-1:0] in_on,
  input  wire logic [adsr_pkg::TIME_W-1:0] in_off,
  input  wire adsr_pkg::cfg_t              cfg,
  output logic                             out_valid,
  output adsr_pkg::item_t                  out_item
);
  import adsr_pkg::*;

  logic              v1_r;
  logic [TIME_W-1:0] age_r;
  logic [TIME_W-1:0] e_r;
  logic              held_r;
  logic              neg_r;
  logic              v2_r;
  item_t             item_r;

  logic              held;
  logic [TIME_W-1:0] d;
  logic              att_le;
  logic              dec_ok;
  item_t             item_nxt;

  assign held = in_on > in_off;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    age_r  <= held ? in_now - in_on : in_off - in_on;
    e_r    <= (in_now > in_off) ? in_now - in_off : '0;
    held_r <= held;
    neg_r  <= in_now < in_on;
    item_r <= item_nxt;
  end

  assign d      = age_r - TIME_W'(cfg.attack);
  assign att_le = age_r <= TIME_W'(cfg.attack);
  assign dec_ok = (d <= TIME_W'(cfg.decay)) && (cfg.decay != '0);

  always_comb begin
    item_nxt.held     = held_r;
    item_nxt.zero_att = cfg.attack == '0;
    item_nxt.rel_e    = e_r[TICK_W-1:0];
    // notes not yet started and released notes past the release ramp are silent
    item_nxt.silent   = neg_r | (!held_r & ((cfg.release_t == '0) |
                        (e_r >= TIME_W'(cfg.release_t))));
    if (att_le) begin
      item_nxt.seg   = SEG_ATTACK;
      item_nxt.mul_a = age_r[TICK_W-1:0];
    end else if (dec_ok) begin
      item_nxt.seg   = SEG_DECAY;
      item_nxt.mul_a = d[TICK_W-1:0];
    end else begin
      item_nxt.seg   = SEG_SUSTAIN;
      item_nxt.mul_a = '0;
    end
  end

  assign out_valid = v2_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

/* rtl/adsr_queue.sv */
// adsr_queue: short queue between front and back
// depends on adsr_pkg
`default_nettype none
module adsr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire adsr_pkg::item_t push_item,
  input  wire logic            pop,
  output logic                 head_valid,
  output adsr_pkg::item_t      head_item,
  output adsr_pkg::qstat_t     stat
);
  import adsr_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  assign head_valid = cnt_r != '0;
  assign head_item  = mem_r[rd_ptr_r];
  assign stat.push  = push;
  assign stat.full  = cnt_r == QCNT_W'(QDEPTH);
  assign stat.empty = cnt_r == '0;

endmodule
`default_nettype wire

/* rtl/adsr_back.sv */
// adsr_back: held-level ramp, release ramp, saturation and floor
// depends on adsr_pkg and adsr_div
`default_nettype none
module adsr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire adsr_pkg::item_t in_item,
  input  wire adsr_pkg::cfg_t  cfg,
  output logic                 out_strobe,
  output logic [adsr_pkg::LVL_W-1:0] out_level,
  output logic [2:0]           out_phase,
  output logic                 out_finished
);
  import adsr_pkg::*;

  typedef struct packed {
    logic              v;
    item_t             it;
    logic              up;
    logic [LVL_W-1:0]  sat;
  } meta_t;

  // first multiply
  logic [PROD_W-1:0] prod_r;
  logic [TICK_W-1:0] dvs_r;
  meta_t             m0_r;
  meta_t             m1_r [DIV_STAGES];
  // saturated held level
  meta_t             mh_r;
  // second multiply
  logic [PROD_W-1:0] prod2_r;
  meta_t             mm_r;
  meta_t             m2_r [DIV_STAGES];
  // output
  logic              strobe_r;
  logic [LVL_W-1:0]  level_r;
  phase_t            phase_r;

  logic              up;
  logic [LVL_W-1:0]  num;
  logic [Q_W-1:0]    q1;
  logic [Q_W-1:0]    q2;
  logic [LVL_W:0]    h;
  logic [LVL_W-1:0]  sat;
  logic [LVL_W-1:0]  lvl;
  phase_t            ph;
  meta_t             mlast;

  assign up  = cfg.sustain >= cfg.peak;
  assign num = (in_item.seg == SEG_ATTACK) ? cfg.peak :
               (up ? cfg.sustain - cfg.peak : cfg.peak - cfg.sustain);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_r.v <= 1'b0;
      mh_r.v <= 1'b0;
      mm_r.v <= 1'b0;
      strobe_r <= 1'b0;
      for (int k = 0; k < DIV_STAGES; k++) begin
        m1_r[k].v <= 1'b0;
        m2_r[k].v <= 1'b0;
      end
    end else begin
      m0_r.v <= in_valid;
      m1_r[0].v <= m0_r.v;
      m2_r[0].v <= mm_r.v;
      for (int k = 1; k < DIV_STAGES; k++) begin
        m1_r[k].v <= m1_r[k-1].v;
        m2_r[k].v <= m2_r[k-1].v;
      end
      mh_r.v <= m1_r[DIV_STAGES-1].v;
      mm_r.v <= mh_r.v;
      strobe_r <= m2_r[DIV_STAGES-1].v;
    end
    prod_r     <= PROD_W'(in_item.mul_a) * PROD_W'(num);
    dvs_r      <= (in_item.seg == SEG_ATTACK) ? cfg.attack : cfg.decay;
    m0_r.it    <= in_item;
    m0_r.up    <= up;
    m0_r.sat   <= '0;
    m1_r[0].it <= m0_r.it;
    m1_r[0].up <= m0_r.up;
    m1_r[0].sat <= m0_r.sat;
    m2_r[0].it <= mm_r.it;
    m2_r[0].up <= mm_r.up;
    m2_r[0].sat <= mm_r.sat;
    for (int k = 1; k < DIV_STAGES; k++) begin
      m1_r[k].it  <= m1_r[k-1].it;
      m1_r[k].up  <= m1_r[k-1].up;
      m1_r[k].sat <= m1_r[k-1].sat;
      m2_r[k].it  <= m2_r[k-1].it;
      m2_r[k].up  <= m2_r[k-1].up;
      m2_r[k].sat <= m2_r[k-1].sat;
    end
    mh_r.it  <= m1_r[DIV_STAGES-1].it;
    mh_r.up  <= m1_r[DIV_STAGES-1].up;
    mh_r.sat <= sat;
    prod2_r  <= PROD_W'(mh_r.it.rel_e) * PROD_W'(mh_r.sat);
    mm_r.it  <= mh_r.it;
    mm_r.up  <= mh_r.up;
    mm_r.sat <= mh_r.sat;
    level_r  <= lvl;
    phase_r  <= ph;
  end

  adsr_div u_div_held (
    .clk        (clk),
    .in_dividend(prod_r),
    .in_divisor (dvs_r),
    .out_quot   (q1)
  );

  adsr_div u_div_rel (
    .clk        (clk),
    .in_dividend(prod2_r),
    .in_divisor (cfg.release_t),
    .out_quot   (q2)
  );

  // held level from the ramp quotient, peak or sustain, saturated at one
  always_comb begin
    unique case (m1_r[DIV_STAGES-1].it.seg)
      SEG_ATTACK:  h = m1_r[DIV_STAGES-1].it.zero_att ? {1'b0, cfg.peak} : {1'b0, q1};
      SEG_DECAY:   h = m1_r[DIV_STAGES-1].up ? {1'b0, cfg.peak} + {1'b0, q1}
                                             : {1'b0, cfg.peak} - {1'b0, q1};
      SEG_SUSTAIN: h = {1'b0, cfg.sustain};
      default:     h = '0;
    endcase
    sat = (h > {1'b0, LEVEL_ONE}) ? LEVEL_ONE : h[LVL_W-1:0];
  end

  assign mlast = m2_r[DIV_STAGES-1];

  always_comb begin
    if (mlast.it.silent) begin
      lvl = '0;
      ph  = PH_SILENT;
    end else if (mlast.it.held) begin
      lvl = mlast.sat;
      unique case (mlast.it.seg)
        SEG_ATTACK:  ph = PH_ATTACK;
        SEG_DECAY:   ph = PH_DECAY;
        SEG_SUSTAIN: ph = PH_SUSTAIN;
        default:     ph = PH_SILENT;
      endcase
    end else begin
      lvl = mlast.sat - q2;
      ph  = PH_RELEASE;
    end
    if (lvl <= cfg.floor_l) begin
      lvl = '0;
      if (ph == PH_RELEASE) ph = PH_SILENT;
    end
  end

  assign out_strobe   = strobe_r;
  assign out_level    = level_r;
  assign out_phase    = phase_r;
  assign out_finished = level_r == '0;

endmodule
`default_nettype wire
